@@ sv/lud_pkg.sv @@
// shared types, widths and lead-byte helpers for the lenient utf-8 decoder
package lud_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned CntW   = 3;
  localparam int unsigned MaxRes = 4;

  // class flags of one code point
  typedef struct packed {
    logic white;
    logic newline;
    logic punct;
    logic alpha;
    logic cjk;
  } cls_t;

  // continuation bytes that a lead byte asks for, zero if it is no lead
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b[7:5] == 3'b110) n = 2'd1;
    else if (b[7:4] == 4'b1110) n = 2'd2;
    else if (b[7:3] == 5'b11110) n = 2'd3;
    return n;
  endfunction

  // payload bits of a lead byte, by sequence length
  function automatic logic [7:0] lead_mask(input logic [1:0] need);
    logic [7:0] m;
    case (need)
      2'd1:    m = 8'h1F;
      2'd2:    m = 8'h0F;
      2'd3:    m = 8'h07;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

@@ sv/lud_byte_if.sv @@
// byte channel: one raw byte and its end-of-segment flag per transaction
interface lud_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

@@ sv/lud_cp_if.sv @@
// code point channel: one classified code point per transaction
interface lud_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  byte_count;
  logic        is_white;
  logic        is_newline;
  logic        is_ascii_punct;
  logic        is_ascii_alpha;
  logic        is_cjk;
  logic        segment_end;
  logic        run_last;

  modport source (
    output valid, output code_point, output byte_count, output is_white,
    output is_newline, output is_ascii_punct, output is_ascii_alpha,
    output is_cjk, output segment_end, output run_last, input ready
  );
  modport sink (
    input valid, input code_point, input byte_count, input is_white,
    input is_newline, input is_ascii_punct, input is_ascii_alpha,
    input is_cjk, input segment_end, input run_last, output ready
  );
endinterface

@@ sv/lenient_utf8_decoder_classifier.sv @@
// lenient utf-8 decoder with code point classification
//
// in_i takes one byte per transaction with last_byte marking the end of a
// segment; out_o gives classified code points, each with its byte count.
// Each byte is decoded in one pass into a list of zero to four results,
// which goes to a small result queue; a result shows on out_o the cycle
// after its byte is taken. A byte that opens or extends a sequence gives
// no result, a completing byte gives one, and a broken sequence replays
// its lead and held continuations as single bytes before the current one.
// Throughput is one byte per cycle while out_o is ready and each byte
// gives at most one result; more results hold off the next byte, as the
// queue drains at most one result per cycle. in_i.ready is high while the
// queue is empty or its last result is being taken, so a stall on out_o
// holds off the byte side only once the final queued result is stuck.
// Reset empties the queue and closes any open sequence.
module lenient_utf8_decoder_classifier import lud_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lud_byte_if.sink   in_i,
  lud_cp_if.source   out_o
);

  // decoder state
  logic [7:0]     lead_q, lead_d;
  logic [7:0]     conts_q [2];
  logic [7:0]     conts_d [2];
  logic [1:0]     need_q, need_d;
  logic [1:0]     held_q, held_d;
  logic [CpW-1:0] partial_q, partial_d;

  // result queue
  logic [CpW-1:0]  q_cp_q  [MaxRes];
  logic [CntW-1:0] q_cnt_q [MaxRes];
  logic [2:0]      q_n_q;
  logic [1:0]      q_rd_q;
  logic            q_seg_q;

  logic [7:0]      b;
  logic            last;
  logic [1:0]      b_need;
  logic            is_cont;
  logic            replay, emit_b, open_b, done;
  logic [2:0]      rep_n, n_new;
  logic [CpW-1:0]  ent_cp  [MaxRes];
  logic [CntW-1:0] ent_cnt [MaxRes];
  logic            in_fire, out_fire;
  logic [CpW-1:0]  cur_cp;
  cls_t            cur_cls;

  assign b       = in_i.byte_in;
  assign last    = in_i.last_byte;
  assign b_need  = lead_need(b);
  assign is_cont = (b[7:6] == 2'b10);

  // next state and what this byte emits
  always_comb begin
    lead_d    = lead_q;
    conts_d   = conts_q;
    need_d    = need_q;
    held_d    = held_q;
    partial_d = partial_q;
    replay    = 1'b0;
    emit_b    = 1'b0;
    open_b    = 1'b0;
    done      = 1'b0;
    if (need_q == 2'd0) begin
      if (b_need == 2'd0 || last) emit_b = 1'b1;
      else open_b = 1'b1;
    end else if (is_cont) begin
      if ({1'b0, held_q} + 3'd1 >= {1'b0, need_q}) begin
        done = 1'b1;
      end else if (last) begin
        replay = 1'b1;
        emit_b = 1'b1;
      end else begin
        partial_d           = {partial_q[CpW-7:0], b[5:0]};
        conts_d[held_q[0]]  = b;
        held_d              = held_q + 2'd1;
      end
    end else begin
      replay = 1'b1;
      if (b_need == 2'd0 || last) emit_b = 1'b1;
      else open_b = 1'b1;
    end
    if (replay || done) begin
      lead_d    = '0;
      need_d    = '0;
      held_d    = '0;
      partial_d = '0;
    end
    if (open_b) begin
      lead_d    = b;
      need_d    = b_need;
      held_d    = '0;
      partial_d = {{(CpW-8){1'b0}}, b & lead_mask(b_need)};
    end
  end

  // result list: replayed bytes first, then the current byte; or one completed code point
  always_comb begin
    rep_n      = replay ? ({1'b0, held_q} + 3'd1) : 3'd0;
    ent_cp[0]  = {{(CpW-8){1'b0}}, lead_q};
    ent_cp[1]  = {{(CpW-8){1'b0}}, conts_q[0]};
    ent_cp[2]  = {{(CpW-8){1'b0}}, conts_q[1]};
    ent_cp[3]  = {{(CpW-8){1'b0}}, b};
    for (int i = 0; i < MaxRes; i++) ent_cnt[i] = CntW'(1);
    if (emit_b) ent_cp[rep_n[1:0]] = {{(CpW-8){1'b0}}, b};
    if (done) begin
      ent_cp[0]  = {partial_q[CpW-7:0], b[5:0]};
      ent_cnt[0] = {1'b0, need_q} + 3'd1;
    end
    n_new = rep_n + {2'b00, emit_b} + {2'b00, done};
  end

  assign in_i.ready = (q_n_q == 3'd0) || (q_n_q == 3'd1 && out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      need_q    <= '0;
      held_q    <= '0;
      partial_q <= '0;
    end else if (in_fire) begin
      lead_q    <= lead_d;
      need_q    <= need_d;
      held_q    <= held_d;
      partial_q <= partial_d;
    end
  end

  // held continuation bytes
  always_ff @(posedge clk_i) begin
    if (in_fire) conts_q <= conts_d;
  end

  // queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_n_q  <= '0;
      q_rd_q <= '0;
    end else if (in_fire) begin
      q_n_q  <= n_new;
      q_rd_q <= '0;
    end else if (out_fire) begin
      q_n_q  <= q_n_q - 3'd1;
      q_rd_q <= q_rd_q + 2'd1;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      q_cp_q  <= ent_cp;
      q_cnt_q <= ent_cnt;
      q_seg_q <= last;
    end
  end

  // output transaction
  assign cur_cp = q_cp_q[q_rd_q];

  lud_classify u_classify (
    .cp_i  (cur_cp),
    .cls_o (cur_cls)
  );

  assign out_o.valid          = (q_n_q != 3'd0);
  assign out_o.code_point     = cur_cp;
  assign out_o.byte_count     = q_cnt_q[q_rd_q];
  assign out_o.is_white       = cur_cls.white;
  assign out_o.is_newline     = cur_cls.newline;
  assign out_o.is_ascii_punct = cur_cls.punct;
  assign out_o.is_ascii_alpha = cur_cls.alpha;
  assign out_o.is_cjk         = cur_cls.cjk;
  assign out_o.run_last       = (q_n_q == 3'd1);
  assign out_o.segment_end    = (q_n_q == 3'd1) && q_seg_q;

  // an open sequence never holds all its continuations
  a_held_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q != 2'd0 |-> held_q < need_q)
    else $error("held continuations reached sequence length");

  // a closed sequence carries no partial state
  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q == 2'd0 |-> held_q == 2'd0 && partial_q == '0 && lead_q == '0)
    else $error("closed sequence left partial state");

  // queue never reads past its four entries
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, q_rd_q} + q_n_q) <= 3'd4)
    else $error("result queue overrun");

  // a decoded multi-byte code point is the only result of its byte
  a_multi_sole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.byte_count != 3'd1 |-> q_n_q == 3'd1 && q_rd_q == 2'd0)
    else $error("multi-byte code point shares its byte with other results");

  // a stalled last result keeps the byte side waiting
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("byte taken while a result is stalled");

endmodule

@@ sv/lud_classify.sv @@
// character class flags of one code point
module lud_classify import lud_pkg::*; (
  input  logic [CpW-1:0] cp_i,
  output cls_t           cls_o
);

  always_comb begin
    cls_o.white   = cp_i inside {[21'h09:21'h0D], 21'h20, 21'h85, 21'hA0, 21'h1680,
                                 [21'h2000:21'h200A], 21'h2028, 21'h2029, 21'h202F,
                                 21'h205F, 21'h3000};
    cls_o.newline = cp_i inside {21'h0A, 21'h0D};
    cls_o.punct   = cp_i inside {[21'h21:21'h2F], [21'h3A:21'h40], [21'h5B:21'h60],
                                 [21'h7B:21'h7E]};
    cls_o.alpha   = cp_i inside {[21'h41:21'h5A], [21'h61:21'h7A]};
    cls_o.cjk     = cp_i inside {[21'h4E00:21'h9FA5], [21'h3040:21'h30FF]};
  end

endmodule
